// ===== rtl/core/pma_pkg.sv =====
// Shared types and constants for the paged memory allocator and translator.
// No dependencies; pma_front, pma_back and the top level refer to this package by scoped names.
package pma_pkg;

  localparam int unsigned OFFSET_BITS_DEF     = 10;
  localparam int unsigned PAGE_INDEX_BITS_DEF = 5;
  localparam int unsigned SEGMENT_BITS_DEF    = 5;
  localparam int unsigned FRAME_COUNT_DEF     = 1024;
  localparam int unsigned MAX_PROCESSES_DEF   = 8;

  localparam int unsigned VA_W    = 20;
  localparam int unsigned PAGES_W = 22;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_ALLOC,
    KIND_FREE,
    KIND_READ,
    KIND_WRITE
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  process_id;
    logic [20:0] alloc_size;
    logic [19:0] virt_address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [19:0] result_address;
    logic [7:0]  read_data;
  } out_t;

  // classified request handed from the front to the back
  typedef struct packed {
    kind_e               kind;
    logic [3:0]          process_id;
    logic [PAGES_W-1:0]  pages;
    logic [VA_W-1:0]     virt_address;
    logic                va_ok;
    logic [7:0]          write_data;
  } cmd_t;

endpackage

// ===== rtl/core/pma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pma_front.sv =====
// Front end: accepts request beats, classifies them and queues them for the back end.
// Depends on pma_pkg.
module pma_front #(
  parameter int unsigned OFFSET_BITS     = pma_pkg::OFFSET_BITS_DEF,
  parameter int unsigned PAGE_INDEX_BITS = pma_pkg::PAGE_INDEX_BITS_DEF,
  parameter int unsigned SEGMENT_BITS    = pma_pkg::SEGMENT_BITS_DEF,
  parameter int unsigned MAX_PROCESSES   = pma_pkg::MAX_PROCESSES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  pma_pkg::in_t  in_data_i,
  input  logic          busy_i,
  output logic          head_valid_o,
  output pma_pkg::cmd_t head_o,
  input  logic          head_pop_i
);

  localparam int unsigned VaSpan = OFFSET_BITS + PAGE_INDEX_BITS + SEGMENT_BITS;
  localparam logic [4:0] MaxPid = 5'(MAX_PROCESSES);
  localparam logic [pma_pkg::PAGES_W-1:0] PageRound =
    pma_pkg::PAGES_W'((1 << OFFSET_BITS) - 1);

  pma_pkg::cmd_t               cmd;
  logic [pma_pkg::PAGES_W-1:0] size_round;
  pma_pkg::cmd_t               q_q [pma_pkg::QDEPTH];
  logic [pma_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [pma_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [pma_pkg::QPTR_W:0]    cnt_q;
  logic                        do_push;
  logic                        do_pop;

  always_comb begin
    size_round       = pma_pkg::PAGES_W'(in_data_i.alloc_size) + PageRound;
    cmd.process_id   = in_data_i.process_id;
    cmd.pages        = size_round >> OFFSET_BITS;
    cmd.virt_address = in_data_i.virt_address;
    cmd.va_ok        = (in_data_i.virt_address >> VaSpan) == '0;
    cmd.write_data   = in_data_i.write_data;
    if (in_data_i.process_id == 4'd0 || {1'b0, in_data_i.process_id} > MaxPid) begin
      cmd.kind = pma_pkg::KIND_BAD;
    end else begin
      case (pma_pkg::mode_e'(in_data_i.mode))
        pma_pkg::MODE_ALLOC: cmd.kind = pma_pkg::KIND_ALLOC;
        pma_pkg::MODE_FREE:  cmd.kind = pma_pkg::KIND_FREE;
        pma_pkg::MODE_READ:  cmd.kind = pma_pkg::KIND_READ;
        default:             cmd.kind = pma_pkg::KIND_WRITE;
      endcase
    end
  end

  assign full         = busy_i || (cnt_q == (pma_pkg::QPTR_W + 1)'(pma_pkg::QDEPTH));
  assign do_push      = push && !full;
  assign head_valid_o = cnt_q != '0;
  assign do_pop       = head_pop_i && head_valid_o;
  assign head_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        q_q[wr_ptr_q] <= cmd;
        wr_ptr_q      <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/pma_back.sv =====
// Back end: clearing pass, page map lookup, byte access, frame allocation and free walk.
// Depends on pma_pkg and pma_ram.
module pma_back #(
  parameter int unsigned OFFSET_BITS     = pma_pkg::OFFSET_BITS_DEF,
  parameter int unsigned PAGE_INDEX_BITS = pma_pkg::PAGE_INDEX_BITS_DEF,
  parameter int unsigned SEGMENT_BITS    = pma_pkg::SEGMENT_BITS_DEF,
  parameter int unsigned FRAME_COUNT     = pma_pkg::FRAME_COUNT_DEF,
  parameter int unsigned MAX_PROCESSES   = pma_pkg::MAX_PROCESSES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  pma_pkg::cmd_t head_i,
  output logic          head_pop_o,
  output logic          clearing_o,
  output logic          res_valid_o,
  output pma_pkg::out_t res_o,
  input  logic          res_ready_i
);

  localparam int unsigned Off     = OFFSET_BITS;
  localparam int unsigned Vpb     = PAGE_INDEX_BITS + SEGMENT_BITS;
  localparam int unsigned Fb      = $clog2(FRAME_COUNT);
  localparam int unsigned Pb      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned MapAw   = Pb + Vpb;
  localparam int unsigned ByteAw  = Fb + Off;
  localparam int unsigned ClrBits = (ByteAw > MapAw) ? ByteAw : MapAw;
  localparam int unsigned Vw      = Vpb + Off + pma_pkg::VA_W;
  localparam int unsigned SumW    = pma_pkg::PAGES_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XLATE,
    ST_BYTE,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_ALLOC_END,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } st_e;

  st_e                 st_q;
  logic [ClrBits-1:0]  clr_q;
  pma_pkg::cmd_t       cmd_q;
  logic [Pb-1:0]       proc_q;
  logic [Fb-1:0]       frm_q;
  logic [Fb-1:0]       prev_q;
  logic                have_prev_q;
  logic [Vpb:0]        vp_q;
  logic [Fb:0]         need_q;
  logic [Fb:0]         freecnt_q;
  logic [Vpb-1:0]      bp_q [MAX_PROCESSES];
  pma_pkg::out_t       res_q;

  logic [Pb-1:0]       hproc;
  logic [Vw-1:0]       hva;
  logic [Vw-1:0]       cva;
  logic [Vpb-1:0]      hbp;
  logic [SumW-1:0]     bp_sum;
  logic [19:0]         hbp_addr;
  logic                refuse;
  logic                hit;

  logic                owner_we;
  logic [Fb-1:0]       owner_waddr;
  logic [3:0]          owner_wdata;
  logic [3:0]          owner_rdata;
  logic                link_we;
  logic [Fb-1:0]       link_waddr;
  logic [Fb:0]         link_wdata;
  logic [Fb:0]         link_rdata;
  logic                map_we;
  logic [MapAw-1:0]    map_waddr;
  logic [Fb:0]         map_wdata;
  logic [MapAw-1:0]    map_raddr;
  logic [Fb:0]         map_rdata;
  logic                byte_we;
  logic [ByteAw-1:0]   byte_waddr;
  logic [ByteAw-1:0]   byte_raddr;
  logic [7:0]          byte_rdata;

  assign hproc    = Pb'(head_i.process_id - 4'd1);
  assign hva      = Vw'(head_i.virt_address);
  assign cva      = Vw'(cmd_q.virt_address);
  assign hbp      = bp_q[hproc];
  assign bp_sum   = SumW'(hbp) + SumW'(head_i.pages);
  assign hbp_addr = 20'({hbp, {Off{1'b0}}});
  assign refuse   = (head_i.pages > pma_pkg::PAGES_W'(freecnt_q)) ||
                    (bp_sum >= SumW'(1 << Vpb));
  assign hit      = map_rdata[Fb] && cmd_q.va_ok;

  assign map_raddr  = {hproc, hva[Off +: Vpb]};
  assign byte_raddr = {map_rdata[Fb-1:0], cva[Off-1:0]};

  assign clearing_o  = st_q == ST_CLEAR;
  assign head_pop_o  = (st_q == ST_IDLE) && head_valid_i;
  assign res_valid_o = st_q == ST_DONE;
  assign res_o       = res_q;

  always_comb begin
    owner_we    = 1'b0;
    owner_waddr = frm_q;
    owner_wdata = '0;
    link_we     = 1'b0;
    link_waddr  = prev_q;
    link_wdata  = {1'b0, frm_q};
    map_we      = 1'b0;
    map_waddr   = {proc_q, vp_q[Vpb-1:0]};
    map_wdata   = {1'b1, frm_q};
    byte_we     = 1'b0;
    byte_waddr  = byte_raddr;
    case (st_q)
      ST_CLEAR: begin
        owner_we    = 1'b1;
        owner_waddr = clr_q[Fb-1:0];
        map_we      = 1'b1;
        map_waddr   = clr_q[MapAw-1:0];
        map_wdata   = '0;
        byte_we     = 1'b1;
        byte_waddr  = clr_q[ByteAw-1:0];
      end
      ST_XLATE: begin
        byte_we = hit && (cmd_q.kind == pma_pkg::KIND_WRITE);
      end
      ST_ALLOC_CHK: begin
        if (owner_rdata == 4'd0) begin
          owner_we    = 1'b1;
          owner_wdata = cmd_q.process_id;
          map_we      = 1'b1;
          link_we     = have_prev_q;
        end
      end
      ST_ALLOC_END: begin
        link_we    = 1'b1;
        link_wdata = {1'b1, {Fb{1'b0}}};
      end
      ST_WALK_CHK: begin
        if (owner_rdata == cmd_q.process_id) begin
          owner_we  = 1'b1;
          map_we    = !vp_q[Vpb];
          map_wdata = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      cmd_q       <= '0;
      proc_q      <= '0;
      frm_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      vp_q        <= '0;
      need_q      <= '0;
      freecnt_q   <= (Fb + 1)'(FRAME_COUNT);
      res_q       <= '0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        bp_q[i] <= '0;
      end
    end else begin
      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head_valid_i) begin
            cmd_q  <= head_i;
            proc_q <= hproc;
            res_q  <= '0;
            case (head_i.kind)
              pma_pkg::KIND_BAD: begin
                res_q.status <= 1'b1;
                st_q         <= ST_DONE;
              end
              pma_pkg::KIND_ALLOC: begin
                if (head_i.pages == '0) begin
                  res_q.result_address <= hbp_addr;
                  st_q                 <= ST_DONE;
                end else if (refuse) begin
                  res_q.status <= 1'b1;
                  st_q         <= ST_DONE;
                end else begin
                  res_q.result_address <= hbp_addr;
                  bp_q[hproc]          <= Vpb'(bp_sum);
                  freecnt_q            <= freecnt_q - (Fb + 1)'(head_i.pages);
                  need_q               <= (Fb + 1)'(head_i.pages);
                  vp_q                 <= {1'b0, hbp};
                  frm_q                <= '0;
                  have_prev_q          <= 1'b0;
                  st_q                 <= ST_ALLOC_RD;
                end
              end
              default: st_q <= ST_XLATE;
            endcase
          end
        end
        ST_XLATE: begin
          case (cmd_q.kind)
            pma_pkg::KIND_FREE: begin
              frm_q <= map_rdata[Fb-1:0];
              vp_q  <= {1'b0, cva[Off +: Vpb]};
              st_q  <= hit ? ST_WALK_RD : ST_DONE;
            end
            pma_pkg::KIND_READ: begin
              res_q.status <= !hit;
              st_q         <= hit ? ST_BYTE : ST_DONE;
            end
            default: begin
              res_q.status <= !hit;
              st_q         <= ST_DONE;
            end
          endcase
        end
        ST_BYTE: begin
          res_q.read_data <= byte_rdata;
          st_q            <= ST_DONE;
        end
        ST_ALLOC_RD: st_q <= ST_ALLOC_CHK;
        ST_ALLOC_CHK: begin
          if (owner_rdata == 4'd0) begin
            prev_q      <= frm_q;
            have_prev_q <= 1'b1;
            vp_q        <= vp_q + 1'b1;
            need_q      <= need_q - 1'b1;
            if (need_q == (Fb + 1)'(1)) begin
              st_q <= ST_ALLOC_END;
            end else begin
              frm_q <= frm_q + 1'b1;
              st_q  <= ST_ALLOC_RD;
            end
          end else begin
            frm_q <= frm_q + 1'b1;
            st_q  <= ST_ALLOC_RD;
          end
        end
        ST_ALLOC_END: st_q <= ST_DONE;
        ST_WALK_RD:   st_q <= ST_WALK_CHK;
        ST_WALK_CHK: begin
          if (owner_rdata == cmd_q.process_id) begin
            bp_q[proc_q] <= (bp_q[proc_q] == '0) ? '0 : bp_q[proc_q] - 1'b1;
            freecnt_q    <= freecnt_q + 1'b1;
            if (link_rdata[Fb]) begin
              st_q <= ST_DONE;
            end else begin
              frm_q <= link_rdata[Fb-1:0];
              // the page number sticks once it runs past the virtual space
              vp_q  <= vp_q[Vpb] ? vp_q : vp_q + 1'b1;
              st_q  <= ST_WALK_RD;
            end
          end else begin
            st_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  pma_ram #(.WIDTH(4), .DEPTH(1 << Fb)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (owner_waddr),
    .wdata_i (owner_wdata),
    .raddr_i (frm_q),
    .rdata_o (owner_rdata)
  );

  pma_ram #(.WIDTH(Fb + 1), .DEPTH(1 << Fb)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (frm_q),
    .rdata_o (link_rdata)
  );

  pma_ram #(.WIDTH(Fb + 1), .DEPTH(1 << MapAw)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  pma_ram #(.WIDTH(8), .DEPTH(1 << ByteAw)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (cmd_q.write_data),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  a_freecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freecnt_q <= (Fb + 1)'(FRAME_COUNT))
    else $error("free frame count above frame total");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !head_pop_o)
    else $error("request taken during clearing pass");

  a_alloc_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_ALLOC_CHK |-> need_q != '0)
    else $error("allocation scan with nothing left to take");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DONE && !res_ready_i |=> st_q == ST_DONE && $stable(res_q))
    else $error("result dropped before hand-over");

endmodule

// ===== rtl/core/paged_memory_allocator_translator.sv =====
// Top level of the paged memory allocator and translator: front end, back end, result register.
// Depends on pma_pkg, pma_front, pma_back (and pma_ram through pma_back).
//
// After reset the block runs a clearing pass over 2**max(log2(FRAME_COUNT)+OFFSET_BITS,
// log2(MAX_PROCESSES)+PAGE_INDEX_BITS+SEGMENT_BITS) addresses (1048576 by default) that zeroes
// the byte store, frame owners and page map; full stays high meanwhile. A two-beat request
// queue separates the front from the back end, and a result register lets a new request in
// while a result waits to be popped. One request is worked at a time: a read does a map read
// then a byte read, both registered; an allocate runs a lowest-free scan of the owner RAM,
// and a free walks the frame chain.
module paged_memory_allocator_translator #(
  parameter int unsigned OFFSET_BITS     = pma_pkg::OFFSET_BITS_DEF,
  parameter int unsigned PAGE_INDEX_BITS = pma_pkg::PAGE_INDEX_BITS_DEF,
  parameter int unsigned SEGMENT_BITS    = pma_pkg::SEGMENT_BITS_DEF,
  parameter int unsigned FRAME_COUNT     = pma_pkg::FRAME_COUNT_DEF,
  parameter int unsigned MAX_PROCESSES   = pma_pkg::MAX_PROCESSES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  pma_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output pma_pkg::out_t out_data_o
);

  logic          clearing;
  logic          head_valid;
  pma_pkg::cmd_t head;
  logic          head_pop;
  logic          res_valid;
  pma_pkg::out_t res;
  logic          res_ready;
  logic          out_valid_q;
  pma_pkg::out_t out_q;

  pma_front #(
    .OFFSET_BITS     (OFFSET_BITS),
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
    .SEGMENT_BITS    (SEGMENT_BITS),
    .MAX_PROCESSES   (MAX_PROCESSES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data_i),
    .busy_i       (clearing),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  pma_back #(
    .OFFSET_BITS     (OFFSET_BITS),
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
    .SEGMENT_BITS    (SEGMENT_BITS),
    .FRAME_COUNT     (FRAME_COUNT),
    .MAX_PROCESSES   (MAX_PROCESSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .clearing_o   (clearing),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign res_ready  = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

endmodule
